// ===== rtl/tmt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Train motion tick package
// Shared constants, codes and the sequencer state type.
// ----------------------------------------------------------------------------
package tmt_pkg;

    localparam int STATIONS_DEF = 16;

    localparam int SPEED_W   = 16;
    localparam int POS_W     = 32;
    localparam int TSQ_W     = 11;
    localparam int PW_W      = 20;
    localparam int CNTCFG_W  = 5;
    localparam int ID_W      = 5;
    localparam int PCT_W     = 7;
    localparam int PROD_W    = SPEED_W + TSQ_W;
    localparam int STEP_W    = PROD_W - 8;
    localparam int NUM_W     = 23;
    localparam int CFG_A_W   = 3;
    localparam int CFG_D_W   = 20;

    localparam int FULL_PERCENT = 100;
    localparam int WINDOW_TICKS = 3;

    localparam logic [1:0] MODE_TRACTION = 2'd0;
    localparam logic [1:0] MODE_COAST    = 2'd1;
    localparam logic [1:0] MODE_BRAKE    = 2'd2;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [CFG_A_W-1:0] REG_SPEED_BAND   = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_BRAKE_LIMIT  = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_ACCEL_LIMIT  = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_COAST_DECEL  = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_TICK_Q8      = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_STOP_DELAY   = 3'd5;
    localparam logic [CFG_A_W-1:0] REG_PARK_WINDOW  = 3'd6;
    localparam logic [CFG_A_W-1:0] REG_STATION_CNT  = 3'd7;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_RD    = 11'b000_0000_0010,
        S_CMP   = 11'b000_0000_0100,
        S_UPD   = 11'b000_0000_1000,
        S_CTRL  = 11'b000_0001_0000,
        S_MULA  = 11'b000_0010_0000,
        S_DIV   = 11'b000_0100_0000,
        S_SPD   = 11'b000_1000_0000,
        S_MULB  = 11'b001_0000_0000,
        S_INTEG = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/tmt_effort_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Effort divider
// Restoring divider, one quotient bit per cycle, for a quotient of 0 to 127.
// ----------------------------------------------------------------------------
module tmt_effort_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [tmt_pkg::NUM_W-1:0]   i_dividend,
    input  wire logic [tmt_pkg::SPEED_W-1:0] i_divisor,
    output logic                             o_done,
    output logic [tmt_pkg::PCT_W-1:0]        o_quotient
);
    import tmt_pkg::*;

    logic [NUM_W-1:0] r_rem, r_dsh;
    logic [PCT_W-1:0] r_q;
    logic [2:0]       r_cnt;
    logic             r_busy, r_done;
    logic             w_ge;

    assign w_ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_rem  <= i_dividend;
            r_dsh  <= NUM_W'(i_divisor) << (PCT_W - 1);
            r_q    <= '0;
            r_cnt  <= 3'(PCT_W - 1);
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q   <= {r_q[PCT_W-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
            r_cnt <= r_cnt - 3'd1;
            if (r_cnt == 3'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule
`default_nettype wire

// ===== rtl/train_motion_tick.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Train motion tick
// Advances one simulated train by one tick per item, or loads a station entry.
// ----------------------------------------------------------------------------
// The slave stream carries items: tuser selects a tick (0) or a station load (1).
// Each item gives exactly one result item on the master stream, holding the
// train state after the item. Configuration registers are written through a
// plain write port (enable, index, data). The user must write them only while
// the block is idle; the block itself does not enforce it. A load item shows
// its result in the cycle right after acceptance. A tick passes through the
// states CTRL, MULA, SPD, MULB and INTEG before its result shows, with DIV
// after MULA while the effort divider runs when it brakes or drives with a
// nonzero limit. An open update window puts the table scan (RD and CMP for
// each entry visited) and then UPD before CTRL.
// The scan reads one table entry at a time from the station memory, and one
// multiplier serves both the speed step and the distance step. The sequencer
// takes the next item at the earliest in the cycle after the result has been
// taken, and takes no new item before the result of the last is taken. When
// the receiver stalls, the result holds steady and tready stays low. After
// reset the train stands at position zero, coasting, with no station known;
// the station table holds nothing until it is loaded.
// ----------------------------------------------------------------------------
module train_motion_tick #(
    parameter int STATIONS = tmt_pkg::STATIONS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // speed_goal[15:0], entry_index[19:16], entry_distance[51:20], zero pad
    input  wire logic [55:0] i_s_axis_tdata,
    // operation[0]
    input  wire logic        i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // speed_now[15:0], position_now[47:16], heading[48], drive_mode[50:49],
    // drive_percent[57:51], station_here[62:58], station_next[67:63],
    // plan_updated[68], zero pad
    output logic [71:0]      o_m_axis_tdata,
    input  wire logic                          i_cfg_we,
    input  wire logic [tmt_pkg::CFG_A_W-1:0]   i_cfg_addr,
    input  wire logic [tmt_pkg::CFG_D_W-1:0]   i_cfg_wdata
);
    import tmt_pkg::*;

    localparam int AW = (STATIONS > 1) ? $clog2(STATIONS) : 1;
    localparam int CW = $clog2(STATIONS + 1);

    // Configuration registers.
    logic [SPEED_W-1:0]  r_band, r_brake, r_accel, r_coast, r_delay;
    logic [TSQ_W-1:0]    r_tsq;
    logic [PW_W-1:0]     r_pw;
    logic [CNTCFG_W-1:0] r_scnt;

    // Train state.
    logic [SPEED_W-1:0] r_speed;
    logic [POS_W-1:0]   r_pos;
    logic               r_heading, r_flag;
    logic [1:0]         r_mode;
    logic [PCT_W-1:0]   r_percent;
    logic [SPEED_W-1:0] r_stopped;
    logic [CW-1:0]      r_here, r_next;

    // Working registers.
    t_state             r_state;
    logic [SPEED_W-1:0] r_target, r_acc, r_lim, r_opa;
    logic [PROD_W-1:0]  r_prod;
    logic [CW-1:0]      r_idx, r_midx;
    logic [POS_W-1:0]   r_rd;
    logic [POS_W-1:0]   r_table [STATIONS];

    logic               w_in_acc;
    logic [SPEED_W-1:0] w_tgt_in;
    logic [3:0]         w_slot;
    logic [POS_W-1:0]   w_dist;
    logic [CW-1:0]      w_count;
    logic [SPEED_W-1:0] w_stop_new;
    logic               w_window;
    logic [PROD_W-1:0]  w_prod;
    logic [STEP_W-1:0]  w_step;
    logic [POS_W:0]     w_diff, w_abs;
    logic               w_match;
    logic               w_gt, w_lt;
    logic [SPEED_W-1:0] w_dbrk, w_dtrc;
    logic [STEP_W:0]    w_sub;
    logic [STEP_W:0]    w_add;
    logic [SPEED_W-1:0] w_nspd;
    logic [POS_W:0]     w_pup;
    logic [POS_W:0]     w_pdn;
    logic               w_div_start, w_div_done;
    logic [PCT_W-1:0]   w_div_q;
    logic [CW:0]        w_mp1;
    logic               w_hd_a;

    assign w_in_acc = i_s_axis_tvalid & o_s_axis_tready;
    assign w_tgt_in = i_s_axis_tdata[15:0];
    assign w_slot   = i_s_axis_tdata[19:16];
    assign w_dist   = i_s_axis_tdata[51:20];

    // Active station count, clamped to the table depth.
    assign w_count = (32'(r_scnt) > STATIONS) ? CW'(STATIONS) : CW'(r_scnt);

    assign w_stop_new = (r_stopped == '1) ? r_stopped : r_stopped + 1'b1;
    assign w_window   = ({1'b0, w_stop_new} >= {1'b0, r_delay}) &&
                        ({1'b0, w_stop_new} < ({1'b0, r_delay} + 17'(WINDOW_TICKS)));

    // The one multiplier, shared by the speed step and the distance step.
    assign w_prod = PROD_W'(r_opa) * PROD_W'(r_tsq);
    assign w_step = r_prod[PROD_W-1:8];

    // Station match: |position - station| <= parking window.
    assign w_diff  = {1'b0, r_pos} - {1'b0, r_rd};
    assign w_abs   = w_diff[POS_W] ? (~w_diff + 1'b1) : w_diff;
    assign w_match = (w_abs <= (POS_W+1)'(r_pw));

    assign w_gt   = ({1'b0, r_speed} > ({1'b0, r_target} + {1'b0, r_band}));
    assign w_lt   = (({1'b0, r_speed} + {1'b0, r_band}) < {1'b0, r_target});
    assign w_dbrk = r_speed - r_target;
    assign w_dtrc = r_target - r_speed;

    assign w_sub = (STEP_W+1)'(r_speed) - (STEP_W+1)'(w_step);
    assign w_add = (STEP_W+1)'(r_speed) + (STEP_W+1)'(w_step);

    always_comb begin
        if (r_mode == MODE_TRACTION) begin
            w_nspd = (w_add > (STEP_W+1)'(16'hFFFF)) ? 16'hFFFF : w_add[SPEED_W-1:0];
        end else begin
            w_nspd = w_sub[STEP_W] ? '0 : w_sub[SPEED_W-1:0];
        end
        if ((r_target == '0) && (w_nspd < r_band)) begin
            w_nspd = '0;
        end
    end

    assign w_pup = {1'b0, r_pos} + (POS_W+1)'(w_step);
    assign w_pdn = {1'b0, r_pos} - (POS_W+1)'(w_step);

    assign w_mp1 = {1'b0, r_midx} + 1'b1;
    // Heading after the reversal at the last station, from up to down.
    assign w_hd_a = ((r_here == w_count) && !r_heading) ? 1'b1 : r_heading;

    assign w_div_start = (r_state == S_MULA) && (r_mode != MODE_COAST) && (r_lim != '0);

    tmt_effort_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (NUM_W'(r_acc) * NUM_W'(FULL_PERCENT)),
        .i_divisor  (r_lim),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band  <= 16'd50;
            r_brake <= 16'd100;
            r_accel <= 16'd100;
            r_coast <= 16'd5;
            r_tsq   <= 11'd256;
            r_delay <= 16'd10;
            r_pw    <= 20'd500;
            r_scnt  <= 5'd9;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SPEED_BAND:  r_band  <= i_cfg_wdata[SPEED_W-1:0];
                REG_BRAKE_LIMIT: r_brake <= i_cfg_wdata[SPEED_W-1:0];
                REG_ACCEL_LIMIT: r_accel <= i_cfg_wdata[SPEED_W-1:0];
                REG_COAST_DECEL: r_coast <= i_cfg_wdata[SPEED_W-1:0];
                REG_TICK_Q8:     r_tsq   <= i_cfg_wdata[TSQ_W-1:0];
                REG_STOP_DELAY:  r_delay <= i_cfg_wdata[SPEED_W-1:0];
                REG_PARK_WINDOW: r_pw    <= i_cfg_wdata[PW_W-1:0];
                REG_STATION_CNT: r_scnt  <= i_cfg_wdata[CNTCFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Station memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_s_axis_tuser == OP_LOAD) && (32'(w_slot) < STATIONS)) begin
            r_table[AW'(w_slot)] <= w_dist;
        end
        r_rd <= r_table[r_idx[AW-1:0]];
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_speed   <= '0;
            r_pos     <= '0;
            r_heading <= 1'b0;
            r_mode    <= MODE_COAST;
            r_percent <= '0;
            r_stopped <= '0;
            r_here    <= '0;
            r_next    <= '0;
            r_flag    <= 1'b0;
            r_idx     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_target <= w_tgt_in;
                        r_idx    <= '0;
                        r_midx   <= '0;
                        if (i_s_axis_tuser == OP_LOAD) begin
                            r_state <= S_OUT;
                        end else if (r_speed == '0) begin
                            r_stopped <= w_stop_new;
                            r_state   <= w_window ? S_RD : S_CTRL;
                        end else begin
                            r_stopped <= '0;
                            r_flag    <= 1'b0;
                            r_state   <= S_CTRL;
                        end
                    end
                end
                S_RD: begin
                    // The memory read of entry r_idx lands in r_rd this edge.
                    r_state <= (r_idx < w_count) ? S_CMP : S_UPD;
                end
                S_CMP: begin
                    if (w_match) begin
                        r_here  <= r_idx + 1'b1;
                        r_midx  <= r_idx;
                        r_state <= S_UPD;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_UPD: begin
                    if (!r_heading) begin
                        r_next <= (w_mp1 < {1'b0, w_count}) ? CW'(w_mp1 + 1'b1) : CW'(w_mp1);
                    end else begin
                        r_next <= (r_midx != '0) ? r_midx : CW'(1);
                    end
                    // Reverse at the last station going up, then at the first going down.
                    r_heading <= ((r_here == CW'(1)) && w_hd_a) ? 1'b0 : w_hd_a;
                    r_flag    <= 1'b1;
                    r_state   <= S_CTRL;
                end
                S_CTRL: begin
                    if (w_gt) begin
                        r_mode <= MODE_BRAKE;
                        r_acc  <= (w_dbrk > r_brake) ? r_brake : w_dbrk;
                        r_opa  <= (w_dbrk > r_brake) ? r_brake : w_dbrk;
                        r_lim  <= r_brake;
                    end else if (w_lt) begin
                        r_mode <= MODE_TRACTION;
                        r_acc  <= (w_dtrc > r_accel) ? r_accel : w_dtrc;
                        r_opa  <= (w_dtrc > r_accel) ? r_accel : w_dtrc;
                        r_lim  <= r_accel;
                    end else begin
                        r_mode <= MODE_COAST;
                        r_opa  <= r_coast;
                        r_lim  <= '0;
                    end
                    r_state <= S_MULA;
                end
                S_MULA: begin
                    r_prod <= w_prod;
                    if (w_div_start) begin
                        r_state <= S_DIV;
                    end else begin
                        r_percent <= '0;
                        r_state   <= S_SPD;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_percent <= w_div_q;
                        r_state   <= S_SPD;
                    end
                end
                S_SPD: begin
                    r_speed <= w_nspd;
                    r_opa   <= w_nspd;
                    r_state <= S_MULB;
                end
                S_MULB: begin
                    r_prod  <= w_prod;
                    r_state <= S_INTEG;
                end
                S_INTEG: begin
                    if (!r_heading) begin
                        r_pos <= w_pup[POS_W] ? '1 : w_pup[POS_W-1:0];
                    end else begin
                        r_pos <= w_pdn[POS_W] ? '0 : w_pdn[POS_W-1:0];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = {3'b000, r_flag, ID_W'(r_next), ID_W'(r_here), r_percent,
                              r_mode, r_heading, r_pos, r_speed};

    // The sequencer never offers a result while it takes an item.
    a_ready_valid_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("ready and result valid together");

    // Effort never exceeds full scale when a result is shown.
    a_percent_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_percent <= PCT_W'(FULL_PERCENT)))
        else $error("effort above full scale");

    // Coasting always reports zero effort.
    a_coast_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (r_mode == MODE_COAST)) |-> (r_percent == '0))
        else $error("effort while coasting");

    // A stalled result stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("result changed under stall");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Train motion tick testbench
// Drives ticks and station loads through the slave stream, predicts each
// result item with an independent model of the train, and checks every result
// item field by field across several register settings.
// ----------------------------------------------------------------------------
module testbench;
    import tmt_pkg::*;

    localparam int RUN_LIMIT = 600000;

    typedef struct {
        logic [15:0] speed;
        logic [31:0] position;
        logic        heading;
        logic [1:0]  mode;
        logic [6:0]  percent;
        logic [4:0]  here;
        logic [4:0]  next;
        logic        updated;
    } motion_t;

    // Scoreboard: holds a private copy of the train state and its settings,
    // and the queue of train states that the block must still report.
    class motion_scoreboard;
        longint band, brake, accel, coast, tsq, delay, window, count;
        longint speed, position, stopped;
        logic   heading, updated;
        logic [1:0] mode;
        logic [6:0] percent;
        logic [4:0] here, next;
        logic [31:0] stations [16];
        motion_t pending [$];
        int errors;

        function new();
            band = 50; brake = 100; accel = 100; coast = 5;
            tsq = 256; delay = 10; window = 500; count = 9;
            speed = 0; position = 0; stopped = 0;
            heading = 0; updated = 0; mode = MODE_COAST; percent = 0;
            here = 0; next = 0; errors = 0;
            foreach (stations[i]) stations[i] = '0;
        endfunction

        function void set_reg(logic [CFG_A_W-1:0] idx, logic [CFG_D_W-1:0] val);
            case (idx)
                REG_SPEED_BAND:  band   = val[15:0];
                REG_BRAKE_LIMIT: brake  = val[15:0];
                REG_ACCEL_LIMIT: accel  = val[15:0];
                REG_COAST_DECEL: coast  = val[15:0];
                REG_TICK_Q8:     tsq    = val[10:0];
                REG_STOP_DELAY:  delay  = val[15:0];
                REG_PARK_WINDOW: window = val[19:0];
                REG_STATION_CNT: count  = val[4:0];
                default: ;
            endcase
        endfunction

        function longint scaled(longint rate);
            return (rate * tsq) >> 8;
        endfunction

        // Scan the table for the station under the train and plan the next one.
        function void plan_stations();
            longint cnt, found, sd;
            cnt = (count > 16) ? 16 : count;
            found = 0;
            for (int i = 0; i < cnt; i++) begin
                sd = stations[i];
                if (position >= sd - window && position <= sd + window) begin
                    here = i + 1;
                    found = i;
                    break;
                end
            end
            if (heading == 1'b0)
                next = (found + 1 < cnt) ? found + 2 : found + 1;
            else
                next = (found != 0) ? found : 1;
            if (here == cnt && heading == 1'b0)
                heading = 1'b1;
            if (here == 1 && heading == 1'b1)
                heading = 1'b0;
            updated = 1'b1;
        endfunction

        function void steer(longint tgt);
            longint acc, nxt;
            if (speed > tgt + band) begin
                mode = MODE_BRAKE;
                acc = speed - tgt;
                if (acc > brake) acc = brake;
                percent = (brake == 0) ? 0 : (FULL_PERCENT * acc) / brake;
                nxt = speed - scaled(acc);
            end else if (speed < tgt - band) begin
                mode = MODE_TRACTION;
                acc = tgt - speed;
                if (acc > accel) acc = accel;
                percent = (accel == 0) ? 0 : (FULL_PERCENT * acc) / accel;
                nxt = speed + scaled(acc);
            end else begin
                mode = MODE_COAST;
                percent = 0;
                nxt = speed - scaled(coast);
            end
            if (nxt < 0) nxt = 0;
            if (nxt > 65535) nxt = 65535;
            if (tgt == 0 && nxt < band) nxt = 0;
            speed = nxt;
        endfunction

        // Note one accepted input item and queue the train state it leads to.
        function void note(logic op, logic [15:0] tgt, logic [3:0] idx, logic [31:0] spot);
            motion_t m;
            if (op == OP_LOAD) begin
                stations[idx] = spot;
            end else begin
                if (speed == 0) begin
                    if (stopped < 65535) stopped++;
                    if (stopped >= delay && stopped < delay + WINDOW_TICKS)
                        plan_stations();
                end else begin
                    stopped = 0;
                    updated = 1'b0;
                end
                steer(tgt);
                if (heading == 1'b0) begin
                    position = position + scaled(speed);
                    if (position > 64'hFFFF_FFFF) position = 64'hFFFF_FFFF;
                end else begin
                    position = position - scaled(speed);
                    if (position < 0) position = 0;
                end
            end
            m.speed = speed; m.position = position; m.heading = heading;
            m.mode = mode; m.percent = percent; m.here = here; m.next = next;
            m.updated = updated;
            pending.push_back(m);
        endfunction

        function void field(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
            end
        endfunction

        // Compare one result item with the oldest queued train state.
        function void check(logic [71:0] d);
            motion_t m;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: result item with none expected, actual %h", $time, d);
                return;
            end
            m = pending.pop_front();
            field("speed_now",     m.speed,    d[15:0]);
            field("position_now",  m.position, d[47:16]);
            field("heading",       m.heading,  d[48]);
            field("drive_mode",    m.mode,     d[50:49]);
            field("drive_percent", m.percent,  d[57:51]);
            field("station_here",  m.here,     d[62:58]);
            field("station_next",  m.next,     d[67:63]);
            field("plan_updated",  m.updated,  d[68]);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tuser = 1'b0;
    logic [55:0] s_tdata = '0;
    logic m_tready = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_A_W-1:0] cfg_addr = '0;
    logic [CFG_D_W-1:0] cfg_wdata = '0;
    wire s_tready;
    wire m_tvalid;
    wire [71:0] m_tdata;

    motion_scoreboard sb = new();
    int cycles = 0;
    int burst_left = 0;
    bit hold_request = 1'b0;

    train_motion_tick u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Run guard: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: the stall pattern rotates between always ready, heavy stalls
    // and rare stalls. A hold request from the main
    // sequence makes it refuse results for a long stretch, which backs the
    // block up until it stops taking input items.
    always @(posedge i_clk) begin
        int hold_count;
        if (hold_request) begin
            hold_request = 1'b0;
            hold_count = 400;
        end
        if (hold_count > 0) begin
            hold_count--;
            m_tready <= 1'b0;
        end else begin
            case ((cycles / 64) % 3)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(1, 0) == 1);
                default: m_tready <= ($urandom_range(9, 0) != 0);
            endcase
        end
    end

    // Result monitor: values are read before this edge's updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check(m_tdata);
    end

    // Offer one item and hold it until the block takes it. Items go out in
    // bursts; between bursts the valid line may drop for a random gap.
    task automatic send_item(logic op, logic [15:0] tgt, logic [3:0] idx, logic [31:0] spot);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(6, 0);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(20, 1);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {4'b0, spot, idx, tgt};
        do @(posedge i_clk); while (!s_tready);
        sb.note(op, tgt, idx, spot);
    endtask

    // Wait until every expected result item has come back.
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // Drain the block, then write all registers with the block idle.
    task automatic configure(logic [CFG_D_W-1:0] vals [8]);
        s_tvalid <= 1'b0;
        burst_left = 0;
        drain();
        repeat (60) @(posedge i_clk);
        for (int i = 0; i < 8; i++) begin
            cfg_we <= 1'b1;
            cfg_addr <= i[CFG_A_W-1:0];
            cfg_wdata <= vals[i];
            sb.set_reg(i[CFG_A_W-1:0], vals[i]);
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random traffic: mostly ticks, with stop runs long enough to open the
    // station window and loads placed near the train so that scans match.
    task automatic random_items(int n);
        int pick;
        int run;
        logic [31:0] spot;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99, 0);
            if (pick < 10) begin
                spot = sb.position + $urandom_range(2000, 0) - 1000;
                if (pick < 3) spot = $urandom;
                send_item(OP_LOAD, $urandom, $urandom, spot);
            end else if (pick < 18) begin
                run = $urandom_range(12, 4);
                repeat (run) send_item(OP_TICK, 16'd0, $urandom, $urandom);
                k += run - 1;
            end else if (pick < 23) begin
                send_item(OP_TICK, $urandom, $urandom, $urandom);
            end else begin
                send_item(OP_TICK, $urandom_range(3000, 0), $urandom, $urandom);
            end
        end
    endtask

    initial begin
        logic [CFG_D_W-1:0] vals [8];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill every station slot before the first tick can scan the table.
        for (int i = 0; i < 16; i++)
            send_item(OP_LOAD, 16'hFFFF, i, (i == 15) ? 32'hFFFF_FFFF : i * 1500);

        // Directed: stand still through the window, full target, brake to a
        // stop, coast inside the band.
        repeat (12) send_item(OP_TICK, 16'd0, 4'd0, 32'd0);
        send_item(OP_TICK, 16'hFFFF, 4'hF, 32'hFFFF_FFFF);
        send_item(OP_TICK, 16'hFFFF, 4'd0, 32'd0);
        send_item(OP_TICK, 16'd1000, 4'd0, 32'd0);
        send_item(OP_TICK, 16'd180, 4'd0, 32'd0);
        send_item(OP_TICK, 16'd0, 4'd0, 32'd0);
        send_item(OP_TICK, 16'd0, 4'd0, 32'd0);

        vals = '{20'd50, 20'd100, 20'd100, 20'd5, 20'd256, 20'd2, 20'd500, 20'd9};
        configure(vals);
        random_items(110);

        // High settings for every register, with a long receiver hold-off.
        vals = '{20'hFFFF, 20'hFFFF, 20'hFFFF, 20'hFFFF, 20'h7FF, 20'd65532,
                 20'd1000000, 20'd16};
        configure(vals);
        hold_request = 1'b1;
        random_items(60);

        // Lower extremes: zero limits, shortest tick, one station.
        vals = '{20'd0, 20'd0, 20'd0, 20'd0, 20'd1, 20'd0, 20'd0, 20'd1};
        configure(vals);
        random_items(70);

        // No stations at all, then a count beyond the table size.
        vals = '{20'd20, 20'd500, 20'd300, 20'd10, 20'd1024, 20'd1, 20'd100000, 20'd0};
        configure(vals);
        random_items(80);
        vals = '{20'd30, 20'd800, 20'd400, 20'd3, 20'd512, 20'd0, 20'd20000, 20'd31};
        configure(vals);
        random_items(80);

        for (int p = 0; p < 3; p++) begin
            vals = '{$urandom_range(200, 0), $urandom_range(2000, 1),
                     $urandom_range(2000, 1), $urandom_range(50, 0),
                     $urandom_range(1024, 1), $urandom_range(4, 0),
                     $urandom_range(50000, 0), $urandom_range(16, 1)};
            configure(vals);
            random_items(80);
        end

        s_tvalid <= 1'b0;
        drain();
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
